/* src/mts_pkg.sv */
// Shared types, codes and constants for the minimum tracking stack.
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 34;
    localparam int FILL_W      = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic pop_start;
        logic pop_done;
    } ctrl_t;

endpackage

`default_nettype wire

/* src/mts_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module mts_ram #(
    parameter int WIDTH = mts_pkg::ENTRY_W,
    parameter int DEPTH = mts_pkg::STACK_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/mts_ctrl.sv */
// Sequencer for the minimum tracking stack: input acceptance and the pop read wait.
`default_nettype none

module mts_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          out_busy,
    input  wire logic          m_tready,
    input  wire logic          pop_go,
    output mts_pkg::ctrl_t     ctrl
);

    mts_pkg::state_t state_reg;
    mts_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::ST_IDLE: begin
                if (ctrl.accept && pop_go) begin
                    state_next = mts_pkg::ST_POP;
                end
            end
            mts_pkg::ST_POP: begin
                state_next = mts_pkg::ST_IDLE;
            end
            default: begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            mts_pkg::ST_IDLE: begin
                ctrl.ready     = !out_busy || m_tready;
                ctrl.accept    = ctrl.ready && s_tvalid;
                ctrl.pop_start = ctrl.ready && s_tvalid && pop_go;
            end
            mts_pkg::ST_POP: begin
                ctrl.pop_done = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/min_tracking_stack.sv */
// Top level of the minimum tracking stack: datapath, output register and assertions.
// Push, query and refused or empty operations give their result in the cycle after
// the input beat; a pop of a held element gives its result after one stack memory read.
// Throughput: one push or query beat per cycle while the output is free or taken;
// a pop holds the input in the pop state while the new top is read from stack memory.
// Reset clears the element count, the minimum register and all handshake state;
// the stack memory itself is not cleared, since no entry is read before it is pushed.
`default_nettype none

module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input beats.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] value
    input  wire logic [1:0]   s_tuser,   // [1:0] command
    // Result beats.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [103:0] m_tdata,   // [31:0] removed_value, [63:32] top_value,
                                         // [95:64] min_value, [102:96] fill_count
    output logic      [1:0]   m_tuser    // [1:0] status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DW     = mts_pkg::DATA_W;
    localparam int EW     = mts_pkg::ENTRY_W;

    // Architectural state. The raw top entry is mirrored in a register so that push and
    // query never wait for the memory; only a pop needs the entry below the top.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DW-1:0]    min_reg;
    logic [DW-1:0]    min_next;
    logic [EW-1:0]    top_raw_reg;
    logic [EW-1:0]    top_raw_next;
    logic [DW-1:0]    removed_hold_reg;
    logic [DW-1:0]    removed_hold_next;

    // Output register.
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [mts_pkg::STATUS_W-1:0] m_status_reg;
    logic [mts_pkg::STATUS_W-1:0] m_status_next;
    logic [DW-1:0]                m_removed_reg;
    logic [DW-1:0]                m_removed_next;
    logic [DW-1:0]                m_top_reg;
    logic [DW-1:0]                m_top_next;
    logic [DW-1:0]                m_min_reg;
    logic [DW-1:0]                m_min_next;
    logic [CNT_W-1:0]             m_count_reg;
    logic [CNT_W-1:0]             m_count_next;

    mts_pkg::ctrl_t ctrl;

    logic [mts_pkg::CMD_W-1:0] command;
    logic [DW-1:0]             value;
    logic                      is_empty;
    logic                      is_full;
    logic                      pop_go;

    logic [EW-1:0] value_ext;
    logic [EW-1:0] min_ext;
    logic [EW-1:0] encoded;
    logic [EW-1:0] restored;
    logic          value_below_min;
    logic          top_encoded;
    logic [DW-1:0] top_decoded;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [EW-1:0]     ram_rdata;
    logic              rd_encoded;
    logic [DW-1:0]     rd_decoded;
    logic [CNT_W-1:0]  below_top_idx;

    logic [31:0] count_wide;

    assign command = s_tuser;
    assign value   = s_tdata;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign pop_go   = (command == mts_pkg::CMD_POP) && !is_empty;

    // Encoding arithmetic is done at entry width, where 2*x - m cannot overflow.
    assign value_ext       = {{(EW - DW){value[DW-1]}}, value};
    assign min_ext         = {{(EW - DW){min_reg[DW-1]}}, min_reg};
    assign encoded         = (value_ext <<< 1) - min_ext;
    assign restored        = (min_ext <<< 1) - top_raw_reg;
    assign value_below_min = $signed(value) < $signed(min_reg);
    assign top_encoded     = $signed(top_raw_reg) < $signed(min_ext);
    assign top_decoded     = top_encoded ? min_reg : top_raw_reg[DW-1:0];

    // An entry below the running minimum is an encoded one; it decodes to the minimum.
    assign rd_encoded = $signed(ram_rdata) < $signed({{(EW - DW){min_reg[DW-1]}}, min_reg});
    assign rd_decoded = rd_encoded ? min_reg : ram_rdata[DW-1:0];

    // A pop reads the entry beneath the current top, which becomes the new top.
    assign below_top_idx = count_reg - CNT_W'(2);
    assign ram_raddr     = below_top_idx[ADDR_W-1:0];

    mts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_busy (m_valid_reg),
        .m_tready (m_tready),
        .pop_go   (pop_go),
        .ctrl     (ctrl)
    );

    mts_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        count_next        = count_reg;
        min_next          = min_reg;
        top_raw_next      = top_raw_reg;
        removed_hold_next = removed_hold_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = value_ext;

        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_removed_next = m_removed_reg;
        m_top_next     = m_top_reg;
        m_min_next     = m_min_reg;
        m_count_next   = m_count_reg;

        if (ctrl.accept) begin
            // Default result: the stack as it stands, which covers query, a refused push
            // and a pop or query on an empty stack.
            m_valid_next   = !ctrl.pop_start;
            m_status_next  = is_empty ? mts_pkg::STATUS_EMPTY : mts_pkg::STATUS_OK;
            m_removed_next = '0;
            m_top_next     = is_empty ? '0 : top_decoded;
            m_min_next     = is_empty ? '0 : min_reg;
            m_count_next   = count_reg;

            if (command == mts_pkg::CMD_PUSH) begin
                if (is_full) begin
                    m_status_next = mts_pkg::STATUS_FULL;
                end else begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (is_empty) begin
                        ram_wdata = value_ext;
                        min_next  = value;
                    end else if (value_below_min) begin
                        ram_wdata = encoded;
                        min_next  = value;
                    end else begin
                        ram_wdata = value_ext;
                    end
                    top_raw_next  = ram_wdata;
                    m_status_next = mts_pkg::STATUS_OK;
                    m_top_next    = value;
                    m_min_next    = min_next;
                    m_count_next  = count_next;
                end
            end else if (ctrl.pop_start) begin
                count_next        = count_reg - CNT_W'(1);
                removed_hold_next = top_decoded;
                if (top_encoded) begin
                    min_next = restored[DW-1:0];
                end
            end
        end

        if (ctrl.pop_done) begin
            // The count and minimum already hold their values after the pop.
            m_valid_next   = 1'b1;
            m_status_next  = mts_pkg::STATUS_OK;
            m_removed_next = removed_hold_reg;
            m_count_next   = count_reg;
            if (count_reg == '0) begin
                m_top_next = '0;
                m_min_next = '0;
            end else begin
                top_raw_next = ram_rdata;
                m_top_next   = rd_decoded;
                m_min_next   = min_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            min_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_raw_reg      <= top_raw_next;
        removed_hold_reg <= removed_hold_next;
        m_status_reg     <= m_status_next;
        m_removed_reg    <= m_removed_next;
        m_top_reg        <= m_top_next;
        m_min_reg        <= m_min_next;
        m_count_reg      <= m_count_next;
    end

    // The fill count field is seven bits wide whatever the depth.
    assign count_wide = 32'(m_count_reg);

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, count_wide[mts_pkg::FILL_W-1:0], m_min_reg, m_top_reg,
                       m_removed_reg};

    // The element count never goes beyond the configured depth.
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("element count exceeds the stack depth");

    // A pop of a held element enters the pop state in the following cycle, with input not ready.
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop_start |=> ctrl.pop_done && !s_tready)
        else $error("pop did not complete in the following cycle");

    // An empty stack always reports zero top and minimum.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_count_reg == '0) |-> (m_top_reg == '0 && m_min_reg == '0))
        else $error("empty stack reported a non-zero top or minimum");

    // A push to a full stack leaves the count unchanged.
    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.accept && command == mts_pkg::CMD_PUSH && is_full) |=> $stable(count_reg))
        else $error("refused push changed the element count");

endmodule

`default_nettype wire
